### rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared definitions for the bounded list with search
// Depth, derived widths, command and status codes, controller states, cell control struct.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;

  // command codes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_APPEND_BACK = 3'd1,
    OP_POP_FRONT   = 3'd2,
    OP_POP_BACK    = 3'd3,
    OP_SEARCH      = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_REPORT
  } state_e;

  // per-cell update controls
  typedef struct packed {
    logic take_prev;  // shift toward back (push front)
    logic take_next;  // shift toward front (remove front)
    logic load;       // write the command value (append back)
  } cell_ctrl_t;

endpackage

### rtl/bls_cell.sv
// ----------------------------------------------------------------------------
// bls_cell: one list entry
// Holds the entry at a fixed index from the front, shifts with its
// neighbors, and compares itself against the search key.
// ----------------------------------------------------------------------------
module bls_cell (
  input  logic                          clk_i,
  input  bls_pkg::cell_ctrl_t           ctrl_i,
  input  logic [bls_pkg::VAL_W-1:0]     prev_i,
  input  logic [bls_pkg::VAL_W-1:0]     next_i,
  input  logic [bls_pkg::VAL_W-1:0]     value_i,
  input  logic                          live_i,
  output logic [bls_pkg::VAL_W-1:0]     data_o,
  output logic                          match_o
);
  import bls_pkg::*;

  logic [VAL_W-1:0] data_q, data_d;

  // entry update
  always_comb begin
    data_d = data_q;
    if (ctrl_i.take_prev) begin
      data_d = prev_i;
    end else if (ctrl_i.take_next) begin
      data_d = next_i;
    end else if (ctrl_i.load) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  // only live entries may match
  assign match_o = live_i && (data_q == value_i);

endmodule

### rtl/bls_first_match.sv
// ----------------------------------------------------------------------------
// bls_first_match: priority encoder over the registered match vector
// Gives the lowest index that matched, and whether any did.
// ----------------------------------------------------------------------------
module bls_first_match (
  input  logic [bls_pkg::DEPTH-1:0] match_i,
  output logic                      found_o,
  output logic [bls_pkg::IDX_W-1:0] index_o
);
  import bls_pkg::*;

  // scan from the back so the frontmost match wins
  always_comb begin
    index_o = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        index_o = IDX_W'(i);
      end
    end
  end

  assign found_o = |match_i;

endmodule

### rtl/bounded_list_with_search.sv
// ----------------------------------------------------------------------------
// bounded_list_with_search: ordered list of up to DEPTH values with search
// Each command is accepted in S_IDLE; S_REPORT then gives one result cycle
// with valid_o. No new command is taken until that result is out; busy is
// high in the result cycle. The result path has no stall. Reset clears the
// count and control; entry contents are not reset.
// ----------------------------------------------------------------------------
module bounded_list_with_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    opcode_i,
  input  logic signed [31:0]            value_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic                          found_o,
  output logic [3:0]                    position_o,
  output logic [4:0]                    occupancy_o
);
  import bls_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  status_e             status_q, status_d;
  logic                search_q, search_d;
  logic [DEPTH-1:0]    match_q, match_d;

  logic                accept;
  logic                full;
  logic                empty;
  op_e                 op;
  logic [VAL_W-1:0]    key;
  logic [VAL_W-1:0]    cell_data [DEPTH];
  logic [DEPTH-1:0]    match_w;
  cell_ctrl_t          ctrl      [DEPTH];
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;

  assign accept = start && (state_q == S_IDLE);
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign op     = op_e'(opcode_i);
  assign key    = VAL_W'(value_i);

  // row of cells; cell 0 is the front
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] prev_w;
    logic [VAL_W-1:0] next_w;

    if (k == 0) begin : g_front
      assign prev_w = key;
    end else begin : g_mid
      assign prev_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_back
      assign next_w = cell_data[k];
    end else begin : g_inner
      assign next_w = cell_data[k+1];
    end

    assign ctrl[k].take_prev = accept && (op == OP_PUSH_FRONT) && !full;
    assign ctrl[k].take_next = accept && (op == OP_POP_FRONT) && !empty;
    assign ctrl[k].load      = accept && (op == OP_APPEND_BACK) && !full &&
                               (count_q == CNT_W'(k));

    bls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[k]),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .value_i (key),
      .live_i  (CNT_W'(k) < count_q),
      .data_o  (cell_data[k]),
      .match_o (match_w[k])
    );
  end

  // command decode and control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    status_d = status_q;
    search_d = search_q;
    match_d  = match_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d  = S_REPORT;
          status_d = ST_DONE;
          search_d = 1'b0;
          match_d  = match_w;
          case (op)
            OP_PUSH_FRONT, OP_APPEND_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              search_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_REPORT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= ST_DONE;
      search_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      search_q <= search_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
  end

  // first match from the front
  bls_first_match u_first_match (
    .match_i (match_q),
    .found_o (hit),
    .index_o (hit_idx)
  );

  // result transaction
  assign busy        = (state_q == S_REPORT);
  assign valid_o     = (state_q == S_REPORT);
  assign status_o    = status_q;
  assign found_o     = search_q && hit;
  assign position_o  = (search_q && hit) ? hit_idx : '0;
  assign occupancy_o = count_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the bounded list with search
// Drives push, append, remove and search commands through the start/busy
// handshake with random gaps, tracks the list in a local model and checks
// every result transaction field by field against the model's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import bls_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned N_CMDS       = 1450;

  // one queued command and one predicted result
  typedef struct {
    logic [2:0]  op;
    logic [31:0] val;
    int unsigned gap;
    bit          hold;   // wait for all results before sending
  } list_cmd_t;

  typedef struct {
    status_e     status;
    logic        found;
    logic [3:0]  position;
    logic [4:0]  occupancy;
  } list_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic [2:0]         opcode_i = OP_PUSH_FRONT;
  logic signed [31:0] value_i = '0;
  logic               busy;
  logic               valid_o;
  logic [1:0]         status_o;
  logic               found_o;
  logic [3:0]         position_o;
  logic [4:0]         occupancy_o;

  list_cmd_t   cmd_q[$];
  list_reply_t reply_q[$];
  int unsigned n_cmds = 0;
  int unsigned wait_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  bit          no_idle = 1'b0;
  logic [31:0] value_pool[8];

  // local copy of the list: ring of slots, front slot and entry count
  logic [31:0] ring[DEPTH];
  int unsigned front_idx = 0;
  int unsigned fill_cnt = 0;

  bounded_list_with_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .occupancy_o (occupancy_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // apply one command to the list copy and queue the result it gives
  task automatic apply_list_cmd(input logic [2:0] op, input logic [31:0] val);
    list_reply_t r;
    bit          hit;
    r.status   = ST_DONE;
    r.found    = 1'b0;
    r.position = '0;
    hit        = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (fill_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          ring[front_idx] = val;
          fill_cnt++;
        end
      end
      OP_APPEND_BACK: begin
        if (fill_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[(front_idx + fill_cnt) % DEPTH] = val;
          fill_cnt++;
        end
      end
      OP_POP_FRONT: begin
        if (fill_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          front_idx = (front_idx + 1) % DEPTH;
          fill_cnt--;
        end
      end
      OP_POP_BACK: begin
        if (fill_cnt == 0) r.status = ST_EMPTY;
        else fill_cnt--;
      end
      OP_SEARCH: begin
        // first match counted from the front
        for (int unsigned k = 0; k < fill_cnt; k++) begin
          if (!hit && ring[(front_idx + k) % DEPTH] == val) begin
            hit        = 1'b1;
            r.found    = 1'b1;
            r.position = k[3:0];
          end
        end
      end
      default: ;  // unused opcodes leave the list alone
    endcase
    r.occupancy = fill_cnt[4:0];
    reply_q.push_back(r);
  endtask

  task automatic add_cmd(input logic [2:0] op, input logic [31:0] val);
    list_cmd_t c;
    c.op   = op;
    c.val  = val;
    c.gap  = no_idle ? 0 : $urandom_range(0, 9);
    c.hold = 1'b0;
    cmd_q.push_back(c);
    n_cmds++;
  endtask

  // mostly values from a small pool so searches hit and duplicates occur
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return value_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [2:0] unused_op();
    return 3'(OP_SEARCH) + 3'($urandom_range(1, 3));
  endfunction

  // driver: presents queued commands, records each accepted transaction
  always @(posedge clk_i) begin : driver
    list_cmd_t nxt;
    logic      fire;
    fire = start && !busy;
    if (fire) begin
      apply_list_cmd(opcode_i, value_i);
      sent_cnt <= sent_cnt + 1;
    end
    if (!rst_ni || (start && !fire)) begin
      // in reset, or still waiting for the current command to be taken
    end else if (cmd_q.size() == 0) begin
      start <= 1'b0;
    end else begin
      nxt = cmd_q[0];
      if (wait_cnt < nxt.gap || (nxt.hold && (fire || sent_cnt != recv_cnt))) begin
        start <= 1'b0;
        if (wait_cnt < nxt.gap) wait_cnt <= wait_cnt + 1;
      end else begin
        void'(cmd_q.pop_front());
        start    <= 1'b1;
        opcode_i <= nxt.op;
        value_i  <= nxt.val;
        wait_cnt <= 0;
      end
    end
  end

  // monitor: compares each result transaction with the oldest prediction
  always @(posedge clk_i) begin : monitor
    list_reply_t want;
    if (rst_ni && valid_o) begin
      recv_cnt <= recv_cnt + 1;
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d found %0d pos %0d occ %0d",
                 $time, status_o, found_o, position_o, occupancy_o);
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, status_o);
        end
        if (found_o !== want.found) begin
          errors++;
          $display("%0t: found mismatch: expected %0d, got %0d",
                   $time, want.found, found_o);
        end
        if (position_o !== want.position) begin
          errors++;
          $display("%0t: position mismatch: expected %0d, got %0d",
                   $time, want.position, position_o);
        end
        if (occupancy_o !== want.occupancy) begin
          errors++;
          $display("%0t: occupancy mismatch: expected %0d, got %0d",
                   $time, want.occupancy, occupancy_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h7FFF_FFFF;
    value_pool[3] = 32'h8000_0000;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();

    // directed: empty list cases, extreme values, duplicates, unused codes
    add_cmd(OP_SEARCH,      32'h0000_0000);
    add_cmd(OP_POP_FRONT,   32'h0000_0000);
    add_cmd(OP_POP_BACK,    32'hFFFF_FFFF);
    add_cmd(3'(OP_SEARCH) + 3'd1, 32'h0000_0000);
    add_cmd(OP_PUSH_FRONT,  32'h7FFF_FFFF);
    add_cmd(OP_APPEND_BACK, 32'h8000_0000);
    add_cmd(OP_APPEND_BACK, 32'hFFFF_FFFF);
    add_cmd(OP_PUSH_FRONT,  32'h0000_0000);
    add_cmd(OP_SEARCH,      32'h8000_0000);
    add_cmd(OP_SEARCH,      32'h0000_0000);
    add_cmd(OP_SEARCH,      32'hFFFF_FFFF);
    add_cmd(OP_SEARCH,      32'h0000_0001);
    add_cmd(OP_APPEND_BACK, 32'h0000_0000);
    add_cmd(OP_SEARCH,      32'h0000_0000);
    add_cmd(OP_POP_BACK,    32'h0000_0000);
    add_cmd(OP_POP_FRONT,   32'hFFFF_FFFF);
    add_cmd(OP_SEARCH,      32'h7FFF_FFFF);
    add_cmd(3'(OP_SEARCH) + 3'd2, 32'hFFFF_FFFF);
    add_cmd(3'(OP_SEARCH) + 3'd3, 32'h5555_5555);
    add_cmd(OP_POP_FRONT,   32'h0000_0000);
    add_cmd(OP_POP_BACK,    32'h0000_0000);
    add_cmd(OP_POP_BACK,    32'h0000_0000);
    add_cmd(OP_POP_FRONT,   32'h0000_0000);
    add_cmd(OP_SEARCH,      32'h7FFF_FFFF);

    // sender drains the pipe once before the random part
    add_cmd(OP_APPEND_BACK, pick_value());
    cmd_q[cmd_q.size() - 1].hold = 1'b1;

    // fill to full and beyond, then drain past empty
    repeat (20) add_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_APPEND_BACK,
                        pick_value());
    repeat (8) add_cmd(OP_SEARCH, pick_value());
    repeat (20) add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, 32'h0);

    // random phases of filling, draining, mixed traffic and search bursts
    while (n_cmds < N_CMDS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      value_pool[$urandom_range(0, 7)] = $urandom();
      if ($urandom_range(0, 9) == 0) begin
        add_cmd(OP_SEARCH, pick_value());
        cmd_q[cmd_q.size() - 1].hold = 1'b1;
      end
      case ($urandom_range(0, 3))
        0: begin
          repeat ($urandom_range(14, 20)) begin
            if ($urandom_range(0, 3) == 0) add_cmd(OP_SEARCH, pick_value());
            else add_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_APPEND_BACK,
                         pick_value());
          end
        end
        1: begin
          repeat ($urandom_range(14, 20)) begin
            if ($urandom_range(0, 3) == 0) add_cmd(OP_SEARCH, pick_value());
            else add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                         $urandom());
          end
        end
        2: begin
          repeat ($urandom_range(10, 30)) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6:
                add_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_APPEND_BACK,
                        pick_value());
              7, 8, 9, 10, 11, 12:
                add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                        $urandom());
              13: add_cmd(unused_op(), $urandom());
              default: add_cmd(OP_SEARCH, pick_value());
            endcase
          end
        end
        default: begin
          repeat ($urandom_range(5, 15)) add_cmd(OP_SEARCH, pick_value());
        end
      endcase
    end

    // reset, then let the driver run
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait until every command is taken and every result is back
    @(negedge clk_i);
    while (cmd_q.size() != 0 || start || sent_cnt != recv_cnt) @(negedge clk_i);
    repeat (4) @(posedge clk_i);

    if (reply_q.size() != 0) begin
      errors += reply_q.size();
      $display("%0t: %0d expected results never arrived", $time, reply_q.size());
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
